// File: sv/mpbf_pkg.sv
// Shared types, codes and sizes for the message pass/block filter core.
package mpbf_pkg;

    // Table geometry
    localparam int FILTER_ENTRIES = 16;
    localparam int ENTRY_W        = $clog2(FILTER_ENTRIES);
    localparam int COUNT_W        = ENTRY_W + 1;

    // Byte counts: lengths include the four ID bytes, eight data bytes carried
    localparam int         DATA_BYTES   = 8;
    localparam logic [3:0] ID_BYTES     = 4'd4;
    localparam logic [3:0] FILTER_BYTES = 4'd12;

    // Operation codes
    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_ACCEPT  = 2'd1,
        OP_FLOW_RX = 2'd2,
        OP_FLOW_TX = 2'd3
    } opcode_t;

    // Filter entry kinds
    typedef enum logic [1:0] {
        KIND_UNUSED = 2'd0,
        KIND_PASS   = 2'd1,
        KIND_BLOCK  = 2'd2,
        KIND_FLOW   = 2'd3
    } kind_t;

    // One input beat
    typedef struct packed {
        opcode_t              opcode;
        logic [ENTRY_W-1:0]   entry_index;
        kind_t                filter_kind;
        logic [31:0]          id_mask;
        logic [31:0]          id_pattern;
        logic [31:0]          id_value;
        logic [3:0]           mask_length;
        logic [3:0]           pattern_length;
        logic [63:0]          data_mask;
        logic [63:0]          data_pattern;
        logic [11:0]          msg_length;
        logic [63:0]          msg_data;
    } item_t;

    // Per-lane findings handed to the merge stage
    typedef struct packed {
        logic is_pass;
        logic pass_hit;
        logic block_hit;
        logic flow_hit;
    } lane_flags_t;

    // One result beat
    typedef struct packed {
        logic               accepted;
        logic               flow_found;
        logic [ENTRY_W-1:0] flow_index;
    } result_t;

    // Clamp a byte count to the table's byte limit
    function automatic logic [3:0] sat_len(input logic [3:0] len);
        return (len > FILTER_BYTES) ? FILTER_BYTES : len;
    endfunction

endpackage

// File: sv/mpbf_lane.sv
// One filter entry: its stored fields and the compare against the current beat.
module mpbf_lane (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic                  load,
    input  logic                  enable,
    input  mpbf_pkg::item_t       item,
    output mpbf_pkg::lane_flags_t flags
);

    mpbf_pkg::kind_t       kind_reg;
    logic [31:0]           id_mask_reg;
    logic [31:0]           id_pattern_reg;
    logic [31:0]           flow_tx_reg;
    logic [3:0]            mask_len_reg;
    logic [3:0]            pat_len_reg;
    logic [63:0]           data_mask_reg;
    logic [63:0]           data_pattern_reg;
    mpbf_pkg::lane_flags_t flags_reg;
    mpbf_pkg::lane_flags_t flags_next;

    // Entry kind is the only field with a reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= mpbf_pkg::KIND_UNUSED;
        end
        else if (wr_en)
        begin
            kind_reg <= item.filter_kind;
        end
    end

    // Entry payload, lengths saturated on the way in
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_mask_reg      <= item.id_mask;
            id_pattern_reg   <= item.id_pattern;
            flow_tx_reg      <= item.id_value;
            mask_len_reg     <= mpbf_pkg::sat_len(item.mask_length);
            pat_len_reg      <= mpbf_pkg::sat_len(item.pattern_length);
            data_mask_reg    <= item.data_mask;
            data_pattern_reg <= item.data_pattern;
        end
    end

    // Compare ID and data bytes against this entry
    always_comb
    begin
        logic       id_hit;
        logic       tx_hit;
        logic       skip;
        logic       too_short;
        logic       mismatch;
        logic       data_hit;
        logic [3:0] mn;
        logic [3:0] pn;
        logic [3:0] need;
        logic [7:0] m_byte;
        logic [7:0] p_byte;
        logic [7:0] d_byte;

        id_hit = ((item.id_value ^ id_pattern_reg) & id_mask_reg) == 32'd0;
        tx_hit = (flow_tx_reg == item.id_value);

        skip = (mask_len_reg <= mpbf_pkg::ID_BYTES) && (pat_len_reg <= mpbf_pkg::ID_BYTES);
        mn   = (mask_len_reg > mpbf_pkg::ID_BYTES) ? mask_len_reg - mpbf_pkg::ID_BYTES : 4'd0;
        pn   = (pat_len_reg > mpbf_pkg::ID_BYTES) ? pat_len_reg - mpbf_pkg::ID_BYTES : 4'd0;
        need = (mn > pn) ? mn : pn;
        too_short = {8'd0, need} > item.msg_length;

        // bytes past either length carry a zero mask or pattern
        mismatch = 1'b0;
        for (int b = 0; b < mpbf_pkg::DATA_BYTES; b++)
        begin
            m_byte = ((4'(b) + mpbf_pkg::ID_BYTES) < mask_len_reg) ?
                     data_mask_reg[8*b +: 8] : 8'd0;
            p_byte = ((4'(b) + mpbf_pkg::ID_BYTES) < pat_len_reg) ?
                     data_pattern_reg[8*b +: 8] : 8'd0;
            d_byte = item.msg_data[8*b +: 8];
            mismatch = mismatch | (((d_byte ^ p_byte) & m_byte) != 8'd0);
        end

        data_hit = skip || (!too_short && !mismatch);

        flags_next.is_pass   = enable && (kind_reg == mpbf_pkg::KIND_PASS);
        flags_next.pass_hit  = flags_next.is_pass && id_hit && data_hit;
        flags_next.block_hit = enable && (kind_reg == mpbf_pkg::KIND_BLOCK) && id_hit && data_hit;
        flags_next.flow_hit  = enable && (kind_reg == mpbf_pkg::KIND_FLOW) &&
                               ((item.opcode == mpbf_pkg::OP_FLOW_RX) ? id_hit : tx_hit);
    end

    // Findings held for the merge stage
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

// File: sv/mpbf_merge.sv
// Combines the lane findings into the accept verdict or the first flow entry.
module mpbf_merge (
    input  mpbf_pkg::opcode_t     op,
    input  mpbf_pkg::lane_flags_t lane_flags [mpbf_pkg::FILTER_ENTRIES],
    output mpbf_pkg::result_t     result
);

    always_comb
    begin
        logic                         pass_seen;
        logic                         passed;
        logic                         blocked;
        logic                         found;
        logic [mpbf_pkg::ENTRY_W-1:0] idx;

        pass_seen = 1'b0;
        passed    = 1'b0;
        blocked   = 1'b0;
        found     = 1'b0;
        idx       = '0;

        // OR-reduce pass/block, priority-encode lowest flow hit
        for (int e = mpbf_pkg::FILTER_ENTRIES - 1; e >= 0; e--)
        begin
            pass_seen = pass_seen | lane_flags[e].is_pass;
            passed    = passed    | lane_flags[e].pass_hit;
            blocked   = blocked   | lane_flags[e].block_hit;
            if (lane_flags[e].flow_hit)
            begin
                found = 1'b1;
                idx   = mpbf_pkg::ENTRY_W'(e);
            end
        end

        result = '0;
        unique case (op) inside
            mpbf_pkg::OP_ACCEPT:
            begin
                result.accepted = !blocked && (!pass_seen || passed);
            end
            mpbf_pkg::OP_FLOW_RX, mpbf_pkg::OP_FLOW_TX:
            begin
                result.flow_found = found;
                result.flow_index = idx;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

// File: sv/message_pass_block_filter_core.sv
// Top level of the message pass/block filter: lanes, merge stage and output register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | receive   | in_valid / in_stall  | opcode, entry_index, filter_kind, id_*, ...
//  out     | send      | out_valid / out_stall| accepted, flow_found, flow_index
//  cfg     | receive   | cfg_valid / cfg_ready| cfg_data (active_count)
//
//  Every beat yields one result beat: the sixteen entry lanes compare in parallel in the
//  cycle the beat is taken and hold their findings in the lane registers, then the merge
//  fills the output register from those findings once the output register is free.
//  A new beat can be taken each cycle while the output drains; a table write lands at the
//  edge it is taken, so the next beat sees it. out_stall holds the output register and,
//  once the lane stage is also full, raises in_stall. Reset clears all entry kinds to
//  unused and active_count to zero; no clearing pass is needed.
module message_pass_block_filter_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mpbf_pkg::COUNT_W-1:0]       cfg_data,
    // input beats
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         opcode,
    input  logic [mpbf_pkg::ENTRY_W-1:0]       entry_index,
    input  logic [1:0]                         filter_kind,
    input  logic [31:0]                        id_mask,
    input  logic [31:0]                        id_pattern,
    input  logic [31:0]                        id_value,
    input  logic [3:0]                         mask_length,
    input  logic [3:0]                         pattern_length,
    input  logic [63:0]                        data_mask,
    input  logic [63:0]                        data_pattern,
    input  logic [11:0]                        msg_length,
    input  logic [63:0]                        msg_data,
    // result beats
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               accepted,
    output logic                               flow_found,
    output logic [mpbf_pkg::ENTRY_W-1:0]       flow_index
);

    logic [mpbf_pkg::COUNT_W-1:0] active_count_reg;
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    mpbf_pkg::opcode_t            s1_op_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    mpbf_pkg::result_t            result_reg;
    mpbf_pkg::result_t            merged;
    mpbf_pkg::item_t              item;
    mpbf_pkg::lane_flags_t        lane_flags [mpbf_pkg::FILTER_ENTRIES];
    logic                         s1_adv;
    logic                         in_accept;

    // Pack the input beat
    always_comb
    begin
        item.opcode         = mpbf_pkg::opcode_t'(opcode);
        item.entry_index    = entry_index;
        item.filter_kind    = mpbf_pkg::kind_t'(filter_kind);
        item.id_mask        = id_mask;
        item.id_pattern     = id_pattern;
        item.id_value       = id_value;
        item.mask_length    = mask_length;
        item.pattern_length = pattern_length;
        item.data_mask      = data_mask;
        item.data_pattern   = data_pattern;
        item.msg_length     = msg_length;
        item.msg_data       = msg_data;
    end

    // Handshake
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_count_reg <= cfg_data;
        end
    end

    // Entry lanes
    for (genvar e = 0; e < mpbf_pkg::FILTER_ENTRIES; e++)
    begin : g_lane
        logic lane_wr;
        logic lane_en;

        assign lane_wr = in_accept && (item.opcode == mpbf_pkg::OP_WRITE) &&
                         (entry_index == mpbf_pkg::ENTRY_W'(e));
        assign lane_en = mpbf_pkg::COUNT_W'(e) < active_count_reg;

        mpbf_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .wr_en  (lane_wr),
            .load   (in_accept),
            .enable (lane_en),
            .item   (item),
            .flags  (lane_flags[e])
        );
    end

    // Merge stage
    mpbf_merge u_merge (
        .op         (s1_op_reg),
        .lane_flags (lane_flags),
        .result     (merged)
    );

    // Stage valid tracking
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg <= item.opcode;
        end
        if (s1_adv)
        begin
            result_reg <= merged;
        end
    end

    assign out_valid  = out_valid_reg;
    assign accepted   = result_reg.accepted;
    assign flow_found = result_reg.flow_found;
    assign flow_index = result_reg.flow_index;

endmodule

// File: tb/sv/tb_message_pass_block_filter_core.sv
// Self-checking testbench for the message pass/block filter core.
`timescale 1ns / 1ps

module tb_message_pass_block_filter_core;
    import mpbf_pkg::*;

    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off in the pressure test
    localparam int QUIET_LIMIT  = 5000;  // cycles with no beat on any channel
    localparam int CFG_SETTLE   = 4;     // pipeline depth plus margin before a register write
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 550;
    localparam int CFG_INTERVAL = 110;

    localparam logic [COUNT_W-1:0] COUNT_NONE  = '0;
    localparam logic [COUNT_W-1:0] COUNT_ALL   = COUNT_W'(FILTER_ENTRIES);
    localparam logic [COUNT_W-1:0] COUNT_SHORT = COUNT_W'(FILTER_ENTRIES - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

    // DUT signals
    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               cfg_valid      = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data       = '0;
    logic               in_valid       = 1'b0;
    logic               in_stall;
    logic [1:0]         opcode         = '0;
    logic [ENTRY_W-1:0] entry_index    = '0;
    logic [1:0]         filter_kind    = '0;
    logic [31:0]        id_mask        = '0;
    logic [31:0]        id_pattern     = '0;
    logic [31:0]        id_value       = '0;
    logic [3:0]         mask_length    = '0;
    logic [3:0]         pattern_length = '0;
    logic [63:0]        data_mask      = '0;
    logic [63:0]        data_pattern   = '0;
    logic [11:0]        msg_length     = '0;
    logic [63:0]        msg_data       = '0;
    logic               out_valid;
    logic               out_stall      = 1'b0;
    logic               accepted;
    logic               flow_found;
    logic [ENTRY_W-1:0] flow_index;

    // run control
    int  send_idle_pct = 0;
    int  stall_pct     = 0;
    bit  hold_request  = 1'b0;
    int  error_count   = 0;
    int  quiet_cycles  = 0;

    // expected result beats, oldest first
    result_t verdicts_due[$];

    // mirror of the filter table and the active count
    kind_t              tbl_kind         [FILTER_ENTRIES];
    logic [31:0]        tbl_id_mask      [FILTER_ENTRIES];
    logic [31:0]        tbl_id_pattern   [FILTER_ENTRIES];
    logic [31:0]        tbl_flow_tx      [FILTER_ENTRIES];
    logic [3:0]         tbl_mask_len     [FILTER_ENTRIES];
    logic [3:0]         tbl_pat_len      [FILTER_ENTRIES];
    logic [63:0]        tbl_data_mask    [FILTER_ENTRIES];
    logic [63:0]        tbl_data_pattern [FILTER_ENTRIES];
    logic [COUNT_W-1:0] active_count = '0;

    message_pass_block_filter_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .entry_index    (entry_index),
        .filter_kind    (filter_kind),
        .id_mask        (id_mask),
        .id_pattern     (id_pattern),
        .id_value       (id_value),
        .mask_length    (mask_length),
        .pattern_length (pattern_length),
        .data_mask      (data_mask),
        .data_pattern   (data_pattern),
        .msg_length     (msg_length),
        .msg_data       (msg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .flow_found     (flow_found),
        .flow_index     (flow_index)
    );

    always #6 clk = ~clk;

    // ---------------------------------------------------------------- prediction

    function automatic bit id_matches(input logic [31:0] id, input int e);
        return ((id ^ tbl_id_pattern[e]) & tbl_id_mask[e]) == 32'd0;
    endfunction

    // Data bytes after the ID section, compared under the stored mask
    function automatic bit data_matches(input int e, input logic [11:0] len,
                                        input logic [63:0] msg);
        int         ml, pl, need, b;
        logic [7:0] m, p, d;
        ml = tbl_mask_len[e];
        pl = tbl_pat_len[e];
        // both lengths within the ID section: nothing to compare
        if (ml <= ID_BYTES && pl <= ID_BYTES)
            return 1'b1;
        need = ((ml > pl) ? ml : pl) - ID_BYTES;
        // message too short for the filter
        if (need > len)
            return 1'b0;
        for (b = 0; b < need && b < DATA_BYTES; b++)
        begin
            // bytes past either length count as zero
            m = (b + ID_BYTES < ml) ? tbl_data_mask[e][8*b +: 8] : 8'h00;
            p = (b + ID_BYTES < pl) ? tbl_data_pattern[e][8*b +: 8] : 8'h00;
            d = msg[8*b +: 8];
            if (((d ^ p) & m) != 8'h00)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Result beat for one input beat; a write updates the table mirror
    function automatic result_t filter_verdict(input item_t it);
        result_t verdict;
        int      span, e;
        bit      pass_seen, passed, blocked, hit;
        verdict   = '0;
        pass_seen = 1'b0;
        passed    = 1'b0;
        blocked   = 1'b0;
        hit       = 1'b0;
        span      = (active_count > FILTER_ENTRIES) ? FILTER_ENTRIES : active_count;
        case (it.opcode)
            OP_WRITE:
            begin
                tbl_kind[it.entry_index]         = it.filter_kind;
                tbl_id_mask[it.entry_index]      = it.id_mask;
                tbl_id_pattern[it.entry_index]   = it.id_pattern;
                tbl_flow_tx[it.entry_index]      = it.id_value;
                tbl_mask_len[it.entry_index]     = (it.mask_length > FILTER_BYTES) ?
                                                   FILTER_BYTES : it.mask_length;
                tbl_pat_len[it.entry_index]      = (it.pattern_length > FILTER_BYTES) ?
                                                   FILTER_BYTES : it.pattern_length;
                tbl_data_mask[it.entry_index]    = it.data_mask;
                tbl_data_pattern[it.entry_index] = it.data_pattern;
            end
            OP_ACCEPT:
            begin
                // first block hit ends the scan
                for (e = 0; e < span && !blocked; e++)
                begin
                    if (tbl_kind[e] == KIND_BLOCK && id_matches(it.id_value, e) &&
                        data_matches(e, it.msg_length, it.msg_data))
                        blocked = 1'b1;
                    else if (tbl_kind[e] == KIND_PASS)
                    begin
                        pass_seen = 1'b1;
                        if (id_matches(it.id_value, e) &&
                            data_matches(e, it.msg_length, it.msg_data))
                            passed = 1'b1;
                    end
                end
                verdict.accepted = !blocked && (!pass_seen || passed);
            end
            default:
            begin
                // first flow-control entry that matches
                for (e = 0; e < span && !hit; e++)
                begin
                    if (tbl_kind[e] == KIND_FLOW)
                    begin
                        hit = (it.opcode == OP_FLOW_RX) ? id_matches(it.id_value, e) :
                                                          (tbl_flow_tx[e] == it.id_value);
                        if (hit)
                        begin
                            verdict.flow_found = 1'b1;
                            verdict.flow_index = e[ENTRY_W-1:0];
                        end
                    end
                end
            end
        endcase
        return verdict;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic logic [63:0] pick_mask();
        logic [63:0] a;
        int          roll;
        a    = {$urandom, $urandom};
        roll = $urandom_range(9);
        if (roll == 0)
            return '0;
        if (roll < 3)
            return '1;
        if (roll < 6)
            return a;
        return a & {$urandom, $urandom} & {$urandom, $urandom};
    endfunction

    // Random beat; lookups mostly aim at a table entry so they reach the hit paths
    function automatic item_t random_item();
        item_t       it;
        int          k, j, roll;
        logic [63:0] bits;
        for (k = 0; k < $bits(item_t); k++)
            it[k] = $urandom_range(1);
        roll = $urandom_range(99);
        if (roll < 25)
            it.opcode = OP_WRITE;
        else if (roll < 65)
            it.opcode = OP_ACCEPT;
        else if (roll < 82)
            it.opcode = OP_FLOW_RX;
        else
            it.opcode = OP_FLOW_TX;
        j = $urandom_range(FILTER_ENTRIES - 1);
        case (it.opcode)
            OP_WRITE:
            begin
                roll = $urandom_range(99);
                it.filter_kind = (roll < 15) ? KIND_UNUSED :
                                 (roll < 45) ? KIND_PASS   :
                                 (roll < 65) ? KIND_BLOCK  : KIND_FLOW;
                bits = pick_mask();
                it.id_mask   = bits[31:0];
                it.data_mask = pick_mask();
            end
            OP_ACCEPT:
            begin
                if ($urandom_range(9) < 7)
                    it.id_value = (tbl_id_pattern[j] & tbl_id_mask[j]) |
                                  (it.id_value & ~tbl_id_mask[j]);
                if ($urandom_range(9) < 7)
                    it.msg_data = (tbl_data_pattern[j] & tbl_data_mask[j]) |
                                  (it.msg_data & ~tbl_data_mask[j]);
                if ($urandom_range(9) < 8)
                begin
                    bits = $urandom_range(FILTER_BYTES);
                    it.msg_length = bits[11:0];
                end
                // near miss on one bit
                if ($urandom_range(9) == 0)
                begin
                    bits = $urandom_range(31);
                    it.id_value[bits[4:0]] = ~it.id_value[bits[4:0]];
                end
            end
            OP_FLOW_RX:
            begin
                if ($urandom_range(9) < 7)
                    it.id_value = (tbl_id_pattern[j] & tbl_id_mask[j]) |
                                  (it.id_value & ~tbl_id_mask[j]);
            end
            default:
            begin
                if ($urandom_range(9) < 7)
                    it.id_value = tbl_flow_tx[j];
            end
        endcase
        return it;
    endfunction

    // Send one beat with a random lead-in gap; valid stays high after acceptance
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        opcode         <= it.opcode;
        entry_index    <= it.entry_index;
        filter_kind    <= it.filter_kind;
        id_mask        <= it.id_mask;
        id_pattern     <= it.id_pattern;
        id_value       <= it.id_value;
        mask_length    <= it.mask_length;
        pattern_length <= it.pattern_length;
        data_mask      <= it.data_mask;
        data_pattern   <= it.data_pattern;
        msg_length     <= it.msg_length;
        msg_data       <= it.msg_data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        verdicts_due.push_back(filter_verdict(it));
    endtask

    task automatic write_entry(input logic [ENTRY_W-1:0] e, input kind_t k,
                               input logic [31:0] m, input logic [31:0] p,
                               input logic [31:0] tx, input logic [3:0] ml,
                               input logic [3:0] pl, input logic [63:0] dm,
                               input logic [63:0] dp);
        item_t it;
        it                = '0;
        it.opcode         = OP_WRITE;
        it.entry_index    = e;
        it.filter_kind    = k;
        it.id_mask        = m;
        it.id_pattern     = p;
        it.id_value       = tx;
        it.mask_length    = ml;
        it.pattern_length = pl;
        it.data_mask      = dm;
        it.data_pattern   = dp;
        send_item(it);
    endtask

    task automatic probe_message(input opcode_t op, input logic [31:0] id,
                                 input logic [11:0] len, input logic [63:0] data);
        item_t it;
        it            = '0;
        it.opcode     = op;
        it.id_value   = id;
        it.msg_length = len;
        it.msg_data   = data;
        send_item(it);
    endtask

    // Register write once the block has drained
    task automatic set_active_count(input logic [COUNT_W-1:0] value);
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        active_count = value;
    endtask

    // ---------------------------------------------------------------- tests

    // Empty table: everything accepted, no flow entry found
    task automatic test_empty_table();
        set_active_count(COUNT_NONE);
        probe_message(OP_ACCEPT, 32'h0, 12'd0, 64'd0);
        probe_message(OP_FLOW_RX, '1, '1, '1);
        set_active_count(COUNT_ALL);
        probe_message(OP_ACCEPT, 32'hDEAD_BEEF, 12'd8, 64'h0123_4567_89AB_CDEF);
        probe_message(OP_FLOW_TX, 32'h0, 12'd0, 64'd0);
    endtask

    task automatic test_filter_cases();
        // pass on the upper ID half; both lengths at the ID size, so no data check
        write_entry(ENTRY_W'(0), KIND_PASS, 32'hFFFF_0000, 32'h1234_0000, 32'h0,
                    4'd4, 4'd4, '1, '1);
        // block one exact ID; mask length saturates, pattern covers two data bytes
        write_entry(ENTRY_W'(1), KIND_BLOCK, '1, 32'h1234_5678, 32'h0, 4'd15, 4'd6, '1,
                    64'hFFFF_FFFF_FFFF_BBAA);
        // flow control on an 11-bit ID
        write_entry(ENTRY_W'(2), KIND_FLOW, 32'h0000_07FF, 32'h0000_07E8, 32'h0000_07E0,
                    4'd0, 4'd0, '0, '0);
        // unused entry: contents must never count
        write_entry(ENTRY_W'(3), KIND_UNUSED, '0, '0, '1, 4'd12, 4'd12, '1, '1);
        write_entry(ENTRY_W'(FILTER_ENTRIES - 1), KIND_FLOW, '1, '1, '1, 4'd5, 4'd13,
                    '0, '1);

        probe_message(OP_ACCEPT, 32'h1234_ABCD, 12'd0, '0);
        probe_message(OP_ACCEPT, 32'h1234_5678, 12'd8, 64'h0000_0000_0000_BBAA);
        // one byte short of what the block entry needs
        probe_message(OP_ACCEPT, 32'h1234_5678, 12'd7, 64'h0000_0000_0000_BBAA);
        // byte past the pattern length is nonzero under the mask
        probe_message(OP_ACCEPT, 32'h1234_5678, '1, 64'h0000_FF00_0000_BBAA);
        probe_message(OP_ACCEPT, '1, 12'd0, '0);

        probe_message(OP_FLOW_RX, 32'h1234_57E8, 12'd0, '0);
        probe_message(OP_FLOW_TX, 32'h0000_07E0, 12'd0, '0);
        probe_message(OP_FLOW_TX, '1, 12'd0, '0);
        probe_message(OP_FLOW_RX, 32'h0, 12'd0, '0);

        // count beyond the table scans every entry; one short hides the last
        set_active_count(COUNT_MAX);
        probe_message(OP_FLOW_TX, '1, 12'd0, '0);
        set_active_count(COUNT_SHORT);
        probe_message(OP_FLOW_TX, '1, 12'd0, '0);
    endtask

    // Receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        int k;
        set_active_count(COUNT_ALL);
        send_idle_pct = 0;
        hold_request  = 1'b1;
        for (k = 0; k < 30; k++)
            send_item(random_item());
        hold_request = 1'b0;
    endtask

    task automatic test_random_traffic(input int sender_idle, input int receiver_idle);
        int          k;
        logic [31:0] pick;
        send_idle_pct = sender_idle;
        stall_pct     = receiver_idle;
        for (k = 0; k < PHASE_ITEMS; k++)
        begin
            if (k % CFG_INTERVAL == 0)
            begin
                case ($urandom_range(6))
                    0:       pick = COUNT_NONE;
                    1:       pick = COUNT_ALL;
                    2:       pick = COUNT_MAX;
                    6:       pick = $urandom_range(FILTER_ENTRIES + 1, COUNT_MAX);
                    default: pick = $urandom_range(1, FILTER_ENTRIES);
                endcase
                set_active_count(pick[COUNT_W-1:0]);
            end
            send_item(random_item());
        end
    endtask

    // ---------------------------------------------------------------- processes

    initial
    begin : test_sequence
        int e;
        for (e = 0; e < FILTER_ENTRIES; e++)
        begin
            tbl_kind[e]         = KIND_UNUSED;
            tbl_id_mask[e]      = '0;
            tbl_id_pattern[e]   = '0;
            tbl_flow_tx[e]      = '0;
            tbl_mask_len[e]     = '0;
            tbl_pat_len[e]      = '0;
            tbl_data_mask[e]    = '0;
            tbl_data_pattern[e] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_filter_cases();
        test_backpressure();
        test_random_traffic(29, 64);
        test_random_traffic(64, 29);
        test_random_traffic(0, 0);

        // drain
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver stall: random, or held for a long stretch on request
    initial
    begin : result_sink
        int held;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request && held < HOLD_CYCLES)
            begin
                out_stall <= 1'b1;
                held++;
            end
            else
            begin
                if (!hold_request)
                    held = 0;
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("result beat with nothing expected: %s %0b %0d",
                       "accepted/flow_found/flow_index", {accepted, flow_found},
                       flow_index);
                error_count++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (accepted !== want.accepted)
                begin
                    $error("accepted: expected %0b, got %0b", want.accepted, accepted);
                    error_count++;
                end
                if (flow_found !== want.flow_found)
                begin
                    $error("flow_found: expected %0b, got %0b", want.flow_found, flow_found);
                    error_count++;
                end
                if (flow_index !== want.flow_index)
                begin
                    $error("flow_index: expected %0d, got %0d", want.flow_index, flow_index);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long with no beat on any channel
    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule

// File: filelist.f
sv/mpbf_pkg.sv
sv/mpbf_lane.sv
sv/mpbf_merge.sv
sv/message_pass_block_filter_core.sv
tb/sv/tb_message_pass_block_filter_core.sv
